FILE: src/cta_pkg.sv
`default_nettype none

package cta_pkg;

    // Face size limit and coordinate precision
    localparam int MAX_FACE_DIM        = 2048;
    localparam int COORD_FRAC_BITS_DEF = 16;

    // Fixed field widths
    localparam int DIR_W   = 16;
    localparam int MAG_W   = DIR_W + 1;
    localparam int DIM_W   = 12;
    localparam int COL_W   = 11;
    localparam int FRAC_W  = 16;
    localparam int IDX_W   = 22;
    localparam int PADDR_W = 4;
    localparam int PDATA_W = 32;

    // Register indexes on the configuration port
    typedef enum logic [1:0] {
        REG_FACE_WIDTH   = 2'd0,
        REG_FACE_HEIGHT  = 2'd1,
        REG_FACES_LOADED = 2'd2
    } t_reg_idx;

    localparam logic [DIM_W-1:0] FACE_DIM_RESET = DIM_W'(512);

    typedef enum logic [2:0] {
        FACE_POS_X = 3'd0,
        FACE_NEG_X = 3'd1,
        FACE_POS_Y = 3'd2,
        FACE_NEG_Y = 3'd3,
        FACE_POS_Z = 3'd4,
        FACE_NEG_Z = 3'd5
    } t_face;

    // Control that travels alongside the datapath
    typedef struct packed {
        logic  valid;
        logic  zero;
        t_face face;
    } t_side;

endpackage

`default_nettype wire

FILE: src/cubemap_texel_address.sv
// From start to o_strobe: stages A, B, the divider stages, M, I and O.
// Throughput: one direction per cycle; busy stays low outside reset.
// The depth is set by the two dividers, which resolve one quotient bit per stage.
// The receiver cannot stall: each result shows on the ports for exactly one cycle.
// Synchronous active-low reset clears all valid bits and loads the register
// reset values (width 512, height 512, faces not loaded); busy is high during reset.
`default_nettype none

module cubemap_texel_address import cta_pkg::*; #(
    parameter int COORD_FRAC_BITS = COORD_FRAC_BITS_DEF
) (
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    // command channel
    input  wire logic                start,
    output logic                     busy,
    input  wire logic [DIR_W-1:0]    i_dir_x,
    input  wire logic [DIR_W-1:0]    i_dir_y,
    input  wire logic [DIR_W-1:0]    i_dir_z,
    // results
    output logic                     o_strobe,
    output logic [2:0]               o_face_id,
    output logic [FRAC_W-1:0]        o_u_frac,
    output logic [FRAC_W-1:0]        o_v_frac,
    output logic [COL_W-1:0]         o_texel_col,
    output logic [COL_W-1:0]         o_texel_row,
    output logic [IDX_W-1:0]         o_texel_index,
    output logic                     o_fetch_valid,
    // configuration
    input  wire logic                psel,
    input  wire logic                penable,
    input  wire logic                pwrite,
    input  wire logic [PADDR_W-1:0]  paddr,
    input  wire logic [PDATA_W-1:0]  pwdata,
    output logic [PDATA_W-1:0]       prdata,
    output logic                     pready
);

    localparam int F       = COORD_FRAC_BITS;
    localparam int DIV_LAT = F + 1;
    localparam int PROD_W  = COL_W + DIM_W;

    // ------------------------------------------------------------------
    // Configuration registers
    // ------------------------------------------------------------------
    logic [DIM_W-1:0] r_face_width;
    logic [DIM_W-1:0] r_face_height;
    logic             r_faces_loaded;
    t_reg_idx         reg_sel;

    assign pready  = 1'b1;
    assign reg_sel = t_reg_idx'(paddr[3:2]);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_face_width   <= FACE_DIM_RESET;
            r_face_height  <= FACE_DIM_RESET;
            r_faces_loaded <= 1'b0;
        end else if (psel && penable && pwrite && pready) begin
            case (reg_sel)
                REG_FACE_WIDTH:   r_face_width   <= pwdata[DIM_W-1:0];
                REG_FACE_HEIGHT:  r_face_height  <= pwdata[DIM_W-1:0];
                REG_FACES_LOADED: r_faces_loaded <= pwdata[0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (reg_sel)
            REG_FACE_WIDTH:   prdata = PDATA_W'(r_face_width);
            REG_FACE_HEIGHT:  prdata = PDATA_W'(r_face_height);
            REG_FACES_LOADED: prdata = PDATA_W'(r_faces_loaded);
            default:          prdata = '0;
        endcase
    end

    // Clamp dimensions; size minus one saturates at zero
    logic [DIM_W-1:0] dim_w, dim_h;
    logic [COL_W-1:0] dim_wm1, dim_hm1;

    always_comb begin
        dim_w   = (r_face_width  > DIM_W'(MAX_FACE_DIM)) ? DIM_W'(MAX_FACE_DIM) : r_face_width;
        dim_h   = (r_face_height > DIM_W'(MAX_FACE_DIM)) ? DIM_W'(MAX_FACE_DIM) : r_face_height;
        dim_wm1 = (dim_w == '0) ? '0 : COL_W'(dim_w - DIM_W'(1));
        dim_hm1 = (dim_h == '0) ? '0 : COL_W'(dim_h - DIM_W'(1));
    end

    // ------------------------------------------------------------------
    // Stage A: register direction and magnitudes
    // ------------------------------------------------------------------
    assign busy = ~i_rst_n;

    logic                    r_a_valid;
    logic signed [DIR_W-1:0] r_a_x, r_a_y, r_a_z;
    logic [MAG_W-1:0]        r_a_ax, r_a_ay, r_a_az;

    function automatic logic [MAG_W-1:0] mag(input logic [DIR_W-1:0] v);
        logic [MAG_W-1:0] ext;
        ext = {v[DIR_W-1], v};
        return v[DIR_W-1] ? MAG_W'(-ext) : ext;
    endfunction

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_valid <= 1'b0;
        end else begin
            r_a_valid <= start && !busy;
        end
    end

    always_ff @(posedge i_clk) begin
        r_a_x  <= i_dir_x;
        r_a_y  <= i_dir_y;
        r_a_z  <= i_dir_z;
        r_a_ax <= mag(i_dir_x);
        r_a_ay <= mag(i_dir_y);
        r_a_az <= mag(i_dir_z);
    end

    // ------------------------------------------------------------------
    // Stage B: face select, numerators and divisor
    // ------------------------------------------------------------------
    logic signed [MAG_W:0] xs, ys, zs, sc, tc, n_s, n_t;
    logic [MAG_W-1:0]      ma;
    t_face                 face;

    always_comb begin
        xs = {{2{r_a_x[DIR_W-1]}}, r_a_x};
        ys = {{2{r_a_y[DIR_W-1]}}, r_a_y};
        zs = {{2{r_a_z[DIR_W-1]}}, r_a_z};
        priority if (r_a_ax > r_a_ay && r_a_ax > r_a_az) begin
            ma = r_a_ax;
            if (r_a_x > 0) begin
                face = FACE_POS_X; sc = -zs; tc = ys;
            end else begin
                face = FACE_NEG_X; sc = zs;  tc = ys;
            end
        end else if (r_a_ay > r_a_az) begin
            ma = r_a_ay;
            if (r_a_y > 0) begin
                face = FACE_POS_Y; sc = xs; tc = -zs;
            end else begin
                face = FACE_NEG_Y; sc = xs; tc = zs;
            end
        end else begin
            ma = r_a_az;
            if (r_a_z > 0) begin
                face = FACE_POS_Z; sc = xs;  tc = ys;
            end else begin
                face = FACE_NEG_Z; sc = -xs; tc = ys;
            end
        end
        n_s = sc + $signed({1'b0, ma});
        n_t = tc + $signed({1'b0, ma});
    end

    t_side            r_b_side;
    logic [MAG_W-1:0] r_b_ns, r_b_nt, r_b_den;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_b_side <= '0;
        end else begin
            r_b_side.valid <= r_a_valid;
            r_b_side.zero  <= (ma == '0);
            r_b_side.face  <= face;
        end
    end

    always_ff @(posedge i_clk) begin
        r_b_ns  <= n_s[MAG_W-1:0];
        r_b_nt  <= n_t[MAG_W-1:0];
        r_b_den <= {ma[MAG_W-2:0], 1'b0};
    end

    // ------------------------------------------------------------------
    // Divider stages: s and t wrapped to their fraction bits
    // ------------------------------------------------------------------
    logic [F-1:0] s_q, t_q;
    t_side        r_div_side [DIV_LAT];

    cta_div #(.FRAC_BITS(F)) u_div_s (
        .i_clk (i_clk),
        .i_num (r_b_ns),
        .i_den (r_b_den),
        .o_quo (s_q)
    );

    cta_div #(.FRAC_BITS(F)) u_div_t (
        .i_clk (i_clk),
        .i_num (r_b_nt),
        .i_den (r_b_den),
        .o_quo (t_q)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < DIV_LAT; k++) r_div_side[k] <= '0;
        end else begin
            r_div_side[0] <= r_b_side;
            for (int k = 1; k < DIV_LAT; k++) r_div_side[k] <= r_div_side[k-1];
        end
    end

    // ------------------------------------------------------------------
    // Stage M: scale to column and row
    // ------------------------------------------------------------------
    logic [COL_W+F-1:0] col_prod, row_prod;
    t_side              r_m_side;
    logic [F-1:0]       r_m_s, r_m_t;
    logic [COL_W-1:0]   r_m_col, r_m_row;

    always_comb begin
        col_prod = (COL_W+F)'(dim_wm1) * (COL_W+F)'(s_q);
        row_prod = (COL_W+F)'(dim_hm1) * (COL_W+F)'(t_q);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_m_side <= '0;
        end else begin
            r_m_side <= r_div_side[DIV_LAT-1];
        end
    end

    always_ff @(posedge i_clk) begin
        r_m_s   <= s_q;
        r_m_t   <= t_q;
        r_m_col <= col_prod[COL_W+F-1:F];
        r_m_row <= row_prod[COL_W+F-1:F];
    end

    // ------------------------------------------------------------------
    // Stage I: row times width
    // ------------------------------------------------------------------
    t_side             r_i_side;
    logic [F-1:0]      r_i_s, r_i_t;
    logic [COL_W-1:0]  r_i_col, r_i_row;
    logic [PROD_W-1:0] r_i_prod;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_i_side <= '0;
        end else begin
            r_i_side <= r_m_side;
        end
    end

    always_ff @(posedge i_clk) begin
        r_i_s    <= r_m_s;
        r_i_t    <= r_m_t;
        r_i_col  <= r_m_col;
        r_i_row  <= r_m_row;
        r_i_prod <= PROD_W'(r_m_row) * PROD_W'(dim_w);
    end

    // ------------------------------------------------------------------
    // Stage O: index add and output register
    // ------------------------------------------------------------------
    logic [PROD_W-1:0] idx_sum;
    logic              r_strobe, r_fetch_valid;
    logic [2:0]        r_face;
    logic [FRAC_W-1:0] r_u, r_v;
    logic [COL_W-1:0]  r_col, r_row;
    logic [IDX_W-1:0]  r_idx;
    logic              keep;

    always_comb begin
        idx_sum = r_i_prod + PROD_W'(r_i_col);
        keep    = !r_i_side.zero;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_strobe      <= 1'b0;
            r_fetch_valid <= 1'b0;
        end else begin
            r_strobe      <= r_i_side.valid;
            r_fetch_valid <= r_i_side.valid && keep && r_faces_loaded
                             && (dim_w != '0) && (dim_h != '0);
        end
    end

    // Zero direction: drop every field to zero
    always_ff @(posedge i_clk) begin
        r_face <= keep ? r_i_side.face : FACE_POS_X;
        r_u    <= keep ? FRAC_W'(r_i_s) : '0;
        r_v    <= keep ? FRAC_W'(r_i_t) : '0;
        r_col  <= keep ? r_i_col : '0;
        r_row  <= keep ? r_i_row : '0;
        r_idx  <= keep ? idx_sum[IDX_W-1:0] : '0;
    end

    assign o_strobe      = r_strobe;
    assign o_fetch_valid = r_fetch_valid;
    assign o_face_id     = r_face;
    assign o_u_frac      = r_u;
    assign o_v_frac      = r_v;
    assign o_texel_col   = r_col;
    assign o_texel_row   = r_row;
    assign o_texel_index = r_idx;

endmodule

`default_nettype wire

FILE: src/cta_div.sv
`default_nettype none

// Pipelined restoring divider: o_quo = low FRAC_BITS bits of
// floor(i_num * 2^FRAC_BITS / i_den), valid for i_num <= i_den.
// One quotient bit per stage.
module cta_div import cta_pkg::*; #(
    parameter int FRAC_BITS = COORD_FRAC_BITS_DEF
) (
    input  wire logic                 i_clk,
    input  wire logic [MAG_W-1:0]     i_num,
    input  wire logic [MAG_W-1:0]     i_den,
    output logic      [FRAC_BITS-1:0] o_quo
);

    logic [MAG_W-1:0]     r_rem [FRAC_BITS+1];
    logic [MAG_W-1:0]     r_den [FRAC_BITS+1];
    logic [FRAC_BITS-1:0] r_quo [FRAC_BITS+1];

    // Integer bit of the quotient: drop it, keep only the remainder
    always_ff @(posedge i_clk) begin
        r_rem[0] <= (i_num >= i_den) ? MAG_W'(i_num - i_den) : i_num;
        r_den[0] <= i_den;
        r_quo[0] <= '0;
    end

    for (genvar k = 1; k <= FRAC_BITS; k++) begin : g_stage
        logic [MAG_W:0] rem2;
        logic           ge;

        always_comb begin
            rem2 = {r_rem[k-1], 1'b0};
            ge   = (rem2 >= {1'b0, r_den[k-1]});
        end

        always_ff @(posedge i_clk) begin
            r_rem[k] <= ge ? MAG_W'(rem2 - {1'b0, r_den[k-1]}) : MAG_W'(rem2);
            r_den[k] <= r_den[k-1];
            r_quo[k] <= {r_quo[k-1][FRAC_BITS-2:0], ge};
        end
    end

    assign o_quo = r_quo[FRAC_BITS];

endmodule

`default_nettype wire

FILE: src/cta_check.sv
`default_nettype none

module cta_check import cta_pkg::*; #(
    parameter int COORD_FRAC_BITS = COORD_FRAC_BITS_DEF
) (
    input wire logic       i_clk,
    input wire logic       i_rst_n,
    input wire logic       start,
    input wire logic       busy,
    input wire logic       o_strobe,
    input wire logic [2:0] o_face_id,
    input wire logic       o_fetch_valid
);

    localparam int LAT = COORD_FRAC_BITS + 6;

    // Every accepted command yields its result a fixed time later
    a_result_follows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |-> ##LAT o_strobe)
        else $error("accepted command produced no result");

    // No result without a matching command
    a_no_spurious: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe |-> $past(start && !busy, LAT))
        else $error("result without accepted command");

    a_fetch_needs_strobe: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_fetch_valid |-> o_strobe)
        else $error("fetch_valid outside a result transfer");

    a_face_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe |-> (o_face_id <= FACE_NEG_Z))
        else $error("face id out of range");

endmodule

bind cubemap_texel_address cta_check #(.COORD_FRAC_BITS(COORD_FRAC_BITS)) u_cta_check (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .start         (start),
    .busy          (busy),
    .o_strobe      (o_strobe),
    .o_face_id     (o_face_id),
    .o_fetch_valid (o_fetch_valid)
);

`default_nettype wire
